// ===== rtl/fgs_pkg.sv =====
package fgs_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int REG_WIDTH     = VALUE_WIDTH - 1;
    localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
    localparam int SUM_WIDTH     = VALUE_WIDTH + 3;
    localparam int INDEX_WIDTH   = 3;
    localparam int PIPE_DEPTH    = 8;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [REG_WIDTH-1:0]          creg_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   wide_t;
    typedef logic [INDEX_WIDTH-1:0]        index_t;

    localparam index_t REG_TIME_STEP         = 3'd0;
    localparam index_t REG_INV_REYNOLDS      = 3'd1;
    localparam index_t REG_INV_DX_SQUARED    = 3'd2;
    localparam index_t REG_INV_DY_SQUARED    = 3'd3;
    localparam index_t REG_INV_DX_QUARTER    = 3'd4;
    localparam index_t REG_INV_DY_QUARTER    = 3'd5;
    localparam index_t REG_UPWIND_DX_QUARTER = 3'd6;
    localparam index_t REG_UPWIND_DY_QUARTER = 3'd7;

    localparam creg_t ONE_RESET     = creg_t'(1) << FRACTION_BITS;
    localparam creg_t QUARTER_RESET = creg_t'(1) << (FRACTION_BITS - 2);

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        value_t p;
        value_t pp;
        value_t q;
        value_t qq;
        value_t r;
        value_t s;
        value_t ap;
        value_t aq;
    } conv_in_t;

    typedef struct packed {
        conv_in_t f_cx;
        conv_in_t f_cy;
        conv_in_t g_cx;
        conv_in_t g_cy;
        value_t   f_d2x;
        value_t   f_d2y;
        value_t   g_d2x;
        value_t   g_d2y;
        value_t   u_center;
        value_t   v_center;
    } prep_t;

    function automatic wide_t widen(input value_t a);
        return wide_t'(a);
    endfunction

    function automatic value_t sat_value(input wide_t x);
        if (x > wide_t'(VALUE_MAX))
        begin
            return VALUE_MAX;
        end
        if (x < wide_t'(VALUE_MIN))
        begin
            return VALUE_MIN;
        end
        return x[VALUE_WIDTH-1:0];
    endfunction

    function automatic value_t add_sat(input value_t a, input value_t b);
        return sat_value(widen(a) + widen(b));
    endfunction

    function automatic value_t sub_sat(input value_t a, input value_t b);
        return sat_value(widen(a) - widen(b));
    endfunction

    function automatic value_t second_diff(input value_t a, input value_t c, input value_t b);
        return sat_value(widen(a) - (widen(c) <<< 1) + widen(b));
    endfunction

    function automatic value_t abs_value(input value_t a);
        if (a == VALUE_MIN)
        begin
            return VALUE_MAX;
        end
        return (a < 0) ? -a : a;
    endfunction

    function automatic value_t from_reg(input creg_t r);
        return value_t'({1'b0, r});
    endfunction

    function automatic prod_t mul_value(input value_t a, input value_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    function automatic value_t round_product(input prod_t p);
        prod_t half;
        prod_t adj;
        logic signed [PROD_WIDTH-FRACTION_BITS-1:0] q;
        half = prod_t'(1) <<< (FRACTION_BITS - 1);
        adj  = (p < 0) ? (p + half - prod_t'(1)) : (p + half);
        q    = adj[PROD_WIDTH-1:FRACTION_BITS];
        if (q > (PROD_WIDTH-FRACTION_BITS)'(VALUE_MAX))
        begin
            return VALUE_MAX;
        end
        if (q < (PROD_WIDTH-FRACTION_BITS)'(VALUE_MIN))
        begin
            return VALUE_MIN;
        end
        return q[VALUE_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/fgs_prep.sv =====
module fgs_prep (
    input  logic            clk,
    input  logic            en,
    input  fgs_pkg::value_t u_west,
    input  fgs_pkg::value_t u_west_north,
    input  fgs_pkg::value_t u_south,
    input  fgs_pkg::value_t u_center,
    input  fgs_pkg::value_t u_north,
    input  fgs_pkg::value_t u_east,
    input  fgs_pkg::value_t v_west,
    input  fgs_pkg::value_t v_south,
    input  fgs_pkg::value_t v_center,
    input  fgs_pkg::value_t v_north,
    input  fgs_pkg::value_t v_east_south,
    input  fgs_pkg::value_t v_east,
    output fgs_pkg::prep_t  prep
);

    fgs_pkg::prep_t prep_reg;
    fgs_pkg::prep_t prep_next;

    function automatic fgs_pkg::conv_in_t make_conv(
        input fgs_pkg::value_t p,
        input fgs_pkg::value_t pp,
        input fgs_pkg::value_t q,
        input fgs_pkg::value_t qq,
        input fgs_pkg::value_t r,
        input fgs_pkg::value_t s
    );
        fgs_pkg::conv_in_t c;
        c.p  = p;
        c.pp = pp;
        c.q  = q;
        c.qq = qq;
        c.r  = r;
        c.s  = s;
        c.ap = fgs_pkg::abs_value(p);
        c.aq = fgs_pkg::abs_value(q);
        return c;
    endfunction

    always_comb
    begin
        prep_next.f_d2x = fgs_pkg::second_diff(u_east, u_center, u_west);
        prep_next.f_d2y = fgs_pkg::second_diff(u_north, u_center, u_south);
        prep_next.g_d2x = fgs_pkg::second_diff(v_east, v_center, v_west);
        prep_next.g_d2y = fgs_pkg::second_diff(v_north, v_center, v_south);
        prep_next.f_cx = make_conv(
            fgs_pkg::add_sat(u_center, u_east), fgs_pkg::add_sat(u_center, u_east),
            fgs_pkg::add_sat(u_west, u_center), fgs_pkg::add_sat(u_west, u_center),
            fgs_pkg::sub_sat(u_center, u_east), fgs_pkg::sub_sat(u_west, u_center));
        prep_next.f_cy = make_conv(
            fgs_pkg::add_sat(v_center, v_east), fgs_pkg::add_sat(u_center, u_north),
            fgs_pkg::add_sat(v_south, v_east_south), fgs_pkg::add_sat(u_south, u_center),
            fgs_pkg::sub_sat(u_center, u_north), fgs_pkg::sub_sat(u_south, u_center));
        prep_next.g_cx = make_conv(
            fgs_pkg::add_sat(u_center, u_north), fgs_pkg::add_sat(v_center, v_east),
            fgs_pkg::add_sat(u_west, u_west_north), fgs_pkg::add_sat(v_west, v_center),
            fgs_pkg::sub_sat(v_center, v_east), fgs_pkg::sub_sat(v_west, v_center));
        prep_next.g_cy = make_conv(
            fgs_pkg::add_sat(v_center, v_north), fgs_pkg::add_sat(v_center, v_north),
            fgs_pkg::add_sat(v_south, v_center), fgs_pkg::add_sat(v_south, v_center),
            fgs_pkg::sub_sat(v_center, v_north), fgs_pkg::sub_sat(v_south, v_center));
        prep_next.u_center = u_center;
        prep_next.v_center = v_center;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

// ===== rtl/fgs_conv.sv =====
module fgs_conv (
    input  logic              clk,
    input  logic              en,
    input  fgs_pkg::conv_in_t terms,
    input  fgs_pkg::creg_t    central_coef,
    input  fgs_pkg::creg_t    upwind_coef,
    output fgs_pkg::value_t   result
);

    fgs_pkg::prod_t  pp_prod_reg;
    fgs_pkg::prod_t  qq_prod_reg;
    fgs_pkg::prod_t  pr_prod_reg;
    fgs_pkg::prod_t  qs_prod_reg;
    fgs_pkg::value_t cen_diff_reg;
    fgs_pkg::value_t up_diff_reg;
    fgs_pkg::prod_t  cen_prod_reg;
    fgs_pkg::prod_t  up_prod_reg;
    fgs_pkg::value_t result_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_prod_reg  <= fgs_pkg::mul_value(terms.p, terms.pp);
            qq_prod_reg  <= fgs_pkg::mul_value(terms.q, terms.qq);
            pr_prod_reg  <= fgs_pkg::mul_value(terms.ap, terms.r);
            qs_prod_reg  <= fgs_pkg::mul_value(terms.aq, terms.s);
            cen_diff_reg <= fgs_pkg::sub_sat(fgs_pkg::round_product(pp_prod_reg),
                                             fgs_pkg::round_product(qq_prod_reg));
            up_diff_reg  <= fgs_pkg::sub_sat(fgs_pkg::round_product(pr_prod_reg),
                                             fgs_pkg::round_product(qs_prod_reg));
            cen_prod_reg <= fgs_pkg::mul_value(fgs_pkg::from_reg(central_coef), cen_diff_reg);
            up_prod_reg  <= fgs_pkg::mul_value(fgs_pkg::from_reg(upwind_coef), up_diff_reg);
            result_reg   <= fgs_pkg::add_sat(fgs_pkg::round_product(cen_prod_reg),
                                             fgs_pkg::round_product(up_prod_reg));
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/fgs_diff.sv =====
module fgs_diff (
    input  logic            clk,
    input  logic            en,
    input  fgs_pkg::value_t d2x,
    input  fgs_pkg::value_t d2y,
    input  fgs_pkg::creg_t  inv_dx_squared,
    input  fgs_pkg::creg_t  inv_dy_squared,
    input  fgs_pkg::creg_t  inv_reynolds,
    output fgs_pkg::value_t result
);

    fgs_pkg::prod_t  xx_prod_reg;
    fgs_pkg::prod_t  yy_prod_reg;
    fgs_pkg::value_t lap_reg;
    fgs_pkg::prod_t  visc_prod_reg;
    fgs_pkg::value_t result_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_prod_reg   <= fgs_pkg::mul_value(d2x, fgs_pkg::from_reg(inv_dx_squared));
            yy_prod_reg   <= fgs_pkg::mul_value(d2y, fgs_pkg::from_reg(inv_dy_squared));
            lap_reg       <= fgs_pkg::add_sat(fgs_pkg::round_product(xx_prod_reg),
                                              fgs_pkg::round_product(yy_prod_reg));
            visc_prod_reg <= fgs_pkg::mul_value(fgs_pkg::from_reg(inv_reynolds), lap_reg);
            result_reg    <= fgs_pkg::round_product(visc_prod_reg);
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/fgs_update.sv =====
module fgs_update (
    input  logic            clk,
    input  logic            en,
    input  fgs_pkg::value_t center,
    input  fgs_pkg::value_t visc,
    input  fgs_pkg::value_t conv_x,
    input  fgs_pkg::value_t conv_y,
    input  fgs_pkg::creg_t  time_step,
    output fgs_pkg::value_t result
);

    fgs_pkg::value_t center_reg [0:5];
    fgs_pkg::value_t inner_reg;
    fgs_pkg::prod_t  step_prod_reg;
    fgs_pkg::value_t result_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            center_reg[0] <= center;
            for (int i = 1; i < 6; i++)
            begin
                center_reg[i] <= center_reg[i-1];
            end
            inner_reg     <= fgs_pkg::sat_value(fgs_pkg::widen(visc) - fgs_pkg::widen(conv_x)
                                                - fgs_pkg::widen(conv_y));
            step_prod_reg <= fgs_pkg::mul_value(fgs_pkg::from_reg(time_step), inner_reg);
            result_reg    <= fgs_pkg::add_sat(center_reg[5],
                                              fgs_pkg::round_product(step_prod_reg));
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/navier_stokes_fg_stencil.sv =====
// Throughput: one transaction per cycle; the eight-stage pipeline moves as one and
// holds every stage while the output transaction is stalled.
// Reset: rst_n clears all valid bits and loads the configuration registers with
// their defaults; the data path registers are not reset.
module navier_stokes_fg_stencil (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  fgs_pkg::index_t       cfg_index,
    input  fgs_pkg::creg_t        cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fgs_pkg::value_t       u_west,
    input  fgs_pkg::value_t       u_west_north,
    input  fgs_pkg::value_t       u_south,
    input  fgs_pkg::value_t       u_center,
    input  fgs_pkg::value_t       u_north,
    input  fgs_pkg::value_t       u_east,
    input  fgs_pkg::value_t       v_west,
    input  fgs_pkg::value_t       v_south,
    input  fgs_pkg::value_t       v_center,
    input  fgs_pkg::value_t       v_north,
    input  fgs_pkg::value_t       v_east_south,
    input  fgs_pkg::value_t       v_east,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fgs_pkg::value_t       f_value,
    output fgs_pkg::value_t       g_value
);

    fgs_pkg::creg_t time_step_reg;
    fgs_pkg::creg_t inv_reynolds_reg;
    fgs_pkg::creg_t inv_dx_squared_reg;
    fgs_pkg::creg_t inv_dy_squared_reg;
    fgs_pkg::creg_t inv_dx_quarter_reg;
    fgs_pkg::creg_t inv_dy_quarter_reg;
    fgs_pkg::creg_t upwind_dx_quarter_reg;
    fgs_pkg::creg_t upwind_dy_quarter_reg;

    logic [fgs_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic                           en;

    fgs_pkg::prep_t  prep;
    fgs_pkg::value_t f_visc;
    fgs_pkg::value_t g_visc;
    fgs_pkg::value_t f_conv_x;
    fgs_pkg::value_t f_conv_y;
    fgs_pkg::value_t g_conv_x;
    fgs_pkg::value_t g_conv_y;

    assign en        = !(valid_reg[fgs_pkg::PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = valid_reg[fgs_pkg::PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[fgs_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg         <= '0;
            inv_reynolds_reg      <= fgs_pkg::ONE_RESET;
            inv_dx_squared_reg    <= fgs_pkg::ONE_RESET;
            inv_dy_squared_reg    <= fgs_pkg::ONE_RESET;
            inv_dx_quarter_reg    <= fgs_pkg::QUARTER_RESET;
            inv_dy_quarter_reg    <= fgs_pkg::QUARTER_RESET;
            upwind_dx_quarter_reg <= '0;
            upwind_dy_quarter_reg <= '0;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                fgs_pkg::REG_TIME_STEP:         time_step_reg         <= cfg_data;
                fgs_pkg::REG_INV_REYNOLDS:      inv_reynolds_reg      <= cfg_data;
                fgs_pkg::REG_INV_DX_SQUARED:    inv_dx_squared_reg    <= cfg_data;
                fgs_pkg::REG_INV_DY_SQUARED:    inv_dy_squared_reg    <= cfg_data;
                fgs_pkg::REG_INV_DX_QUARTER:    inv_dx_quarter_reg    <= cfg_data;
                fgs_pkg::REG_INV_DY_QUARTER:    inv_dy_quarter_reg    <= cfg_data;
                fgs_pkg::REG_UPWIND_DX_QUARTER: upwind_dx_quarter_reg <= cfg_data;
                fgs_pkg::REG_UPWIND_DY_QUARTER: upwind_dy_quarter_reg <= cfg_data;
            endcase
        end
    end

    fgs_prep u_prep (
        .clk          (clk),
        .en           (en),
        .u_west       (u_west),
        .u_west_north (u_west_north),
        .u_south      (u_south),
        .u_center     (u_center),
        .u_north      (u_north),
        .u_east       (u_east),
        .v_west       (v_west),
        .v_south      (v_south),
        .v_center     (v_center),
        .v_north      (v_north),
        .v_east_south (v_east_south),
        .v_east       (v_east),
        .prep         (prep)
    );

    fgs_diff u_f_diff (
        .clk            (clk),
        .en             (en),
        .d2x            (prep.f_d2x),
        .d2y            (prep.f_d2y),
        .inv_dx_squared (inv_dx_squared_reg),
        .inv_dy_squared (inv_dy_squared_reg),
        .inv_reynolds   (inv_reynolds_reg),
        .result         (f_visc)
    );

    fgs_diff u_g_diff (
        .clk            (clk),
        .en             (en),
        .d2x            (prep.g_d2x),
        .d2y            (prep.g_d2y),
        .inv_dx_squared (inv_dx_squared_reg),
        .inv_dy_squared (inv_dy_squared_reg),
        .inv_reynolds   (inv_reynolds_reg),
        .result         (g_visc)
    );

    fgs_conv u_f_conv_x (
        .clk          (clk),
        .en           (en),
        .terms        (prep.f_cx),
        .central_coef (inv_dx_quarter_reg),
        .upwind_coef  (upwind_dx_quarter_reg),
        .result       (f_conv_x)
    );

    fgs_conv u_f_conv_y (
        .clk          (clk),
        .en           (en),
        .terms        (prep.f_cy),
        .central_coef (inv_dy_quarter_reg),
        .upwind_coef  (upwind_dy_quarter_reg),
        .result       (f_conv_y)
    );

    fgs_conv u_g_conv_x (
        .clk          (clk),
        .en           (en),
        .terms        (prep.g_cx),
        .central_coef (inv_dx_quarter_reg),
        .upwind_coef  (upwind_dx_quarter_reg),
        .result       (g_conv_x)
    );

    fgs_conv u_g_conv_y (
        .clk          (clk),
        .en           (en),
        .terms        (prep.g_cy),
        .central_coef (inv_dy_quarter_reg),
        .upwind_coef  (upwind_dy_quarter_reg),
        .result       (g_conv_y)
    );

    fgs_update u_f_update (
        .clk       (clk),
        .en        (en),
        .center    (prep.u_center),
        .visc      (f_visc),
        .conv_x    (f_conv_x),
        .conv_y    (f_conv_y),
        .time_step (time_step_reg),
        .result    (f_value)
    );

    fgs_update u_g_update (
        .clk       (clk),
        .en        (en),
        .center    (prep.v_center),
        .visc      (g_visc),
        .conv_x    (g_conv_x),
        .conv_y    (g_conv_y),
        .time_step (time_step_reg),
        .result    (g_value)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import fgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int CALM_ITEMS     = 250;

    typedef struct {
        value_t f;
        value_t g;
    } momentum_t;

    typedef value_t cell_t [12];

    class momentum_scoreboard;
        momentum_t pending[$];
        int        errors;
        longint    settings [8];

        function void reset_settings();
            settings[0] = 0;
            settings[1] = 64'sd1 << FRACTION_BITS;
            settings[2] = 64'sd1 << FRACTION_BITS;
            settings[3] = 64'sd1 << FRACTION_BITS;
            settings[4] = 64'sd1 << (FRACTION_BITS - 2);
            settings[5] = 64'sd1 << (FRACTION_BITS - 2);
            settings[6] = 0;
            settings[7] = 0;
        endfunction

        function longint clip(longint x);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (x > hi)
            begin
                return hi;
            end
            if (x < lo)
            begin
                return lo;
            end
            return x;
        endfunction

        function longint fixmul(longint a, longint b);
            logic signed [127:0] p;
            logic signed [127:0] m;
            logic signed [127:0] q;
            p = 128'(a) * 128'(b);
            m = (p < 0) ? -p : p;
            q = (m + (128'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
            if (p < 0)
            begin
                q = -q;
            end
            if (q > 128'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (q < -128'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return longint'(q);
        endfunction

        function longint magnitude(longint x);
            return clip(x < 0 ? -x : x);
        endfunction

        function longint convection(longint c, longint w, longint p, longint pp,
                                    longint q, longint qq, longint r, longint s);
            longint cen;
            longint up;
            cen = fixmul(c, clip(fixmul(p, pp) - fixmul(q, qq)));
            up  = fixmul(w, clip(fixmul(magnitude(p), r) - fixmul(magnitude(q), s)));
            return clip(cen + up);
        endfunction

        function void note_cell(cell_t c);
            longint uw, uwn, us, uc, un, ue, vw, vs, vc, vn, ves, ve;
            longint xx, yy, cx, cy;
            momentum_t m;
            uw = c[0]; uwn = c[1]; us = c[2]; uc = c[3]; un = c[4]; ue = c[5];
            vw = c[6]; vs = c[7]; vc = c[8]; vn = c[9]; ves = c[10]; ve = c[11];
            xx = fixmul(clip(ue - 2 * uc + uw), settings[2]);
            yy = fixmul(clip(un - 2 * uc + us), settings[3]);
            cx = convection(settings[4], settings[6], clip(uc + ue), clip(uc + ue),
                            clip(uw + uc), clip(uw + uc), clip(uc - ue), clip(uw - uc));
            cy = convection(settings[5], settings[7], clip(vc + ve), clip(uc + un),
                            clip(vs + ves), clip(us + uc), clip(uc - un), clip(us - uc));
            m.f = value_t'(clip(uc + fixmul(settings[0],
                      clip(fixmul(settings[1], clip(xx + yy)) - cx - cy))));
            xx = fixmul(clip(ve - 2 * vc + vw), settings[2]);
            yy = fixmul(clip(vn - 2 * vc + vs), settings[3]);
            cx = convection(settings[4], settings[6], clip(uc + un), clip(vc + ve),
                            clip(uw + uwn), clip(vw + vc), clip(vc - ve), clip(vw - vc));
            cy = convection(settings[5], settings[7], clip(vc + vn), clip(vc + vn),
                            clip(vs + vc), clip(vs + vc), clip(vc - vn), clip(vs - vc));
            m.g = value_t'(clip(vc + fixmul(settings[0],
                      clip(fixmul(settings[1], clip(xx + yy)) - cx - cy))));
            pending.push_back(m);
        endfunction

        function void check_result(value_t f, value_t g);
            momentum_t m;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result f=%h g=%h", $time, f, g);
                errors++;
                return;
            end
            m = pending.pop_front();
            if (f !== m.f)
            begin
                $display("%0t: f_value expected %h actual %h", $time, m.f, f);
                errors++;
            end
            if (g !== m.g)
            begin
                $display("%0t: g_value expected %h actual %h", $time, m.g, g);
                errors++;
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   cfg_en;
    index_t cfg_index;
    creg_t  cfg_data;
    logic   in_valid;
    logic   in_stall;
    value_t cell_in [12];
    logic   out_valid;
    logic   out_stall;
    value_t f_value;
    value_t g_value;

    momentum_scoreboard board;
    int  idle_cycles;
    bit  calm;
    bit  stall_on;

    navier_stokes_fg_stencil dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .u_west(cell_in[0]), .u_west_north(cell_in[1]), .u_south(cell_in[2]),
        .u_center(cell_in[3]), .u_north(cell_in[4]), .u_east(cell_in[5]),
        .v_west(cell_in[6]), .v_south(cell_in[7]), .v_center(cell_in[8]),
        .v_north(cell_in[9]), .v_east_south(cell_in[10]), .v_east(cell_in[11]),
        .out_valid(out_valid), .out_stall(out_stall),
        .f_value(f_value), .g_value(g_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_result(f_value, g_value);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always
    begin
        int n;
        @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 18);
            out_stall <= 1'b1;
            repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
    end

    function automatic value_t pick_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return value_t'($urandom);
            3: return value_t'($urandom);
            default: return value_t'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh2_0000);
        endcase
    endfunction

    task automatic write_setting(index_t idx, creg_t data);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_en    <= 1'b0;
        board.settings[idx] = longint'(data);
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic send_cell(cell_t c);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int k = 0; k < 12; k++)
        begin
            cell_in[k] <= c[k];
        end
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_cell(c);
    endtask

    task automatic random_cells(int count);
        cell_t c;
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 12; k++)
            begin
                c[k] = pick_value();
            end
            send_cell(c);
        end
        in_valid <= 1'b0;
    endtask

    task automatic random_settings();
        for (int k = 0; k < 8; k++)
        begin
            case ($urandom_range(0, 3))
                0: write_setting(index_t'(k), creg_t'($urandom));
                1: write_setting(index_t'(k), '1);
                default: write_setting(index_t'(k), creg_t'($urandom_range(0, 32'h0002_0000)));
            endcase
        end
    endtask

    initial
    begin
        cell_t c;
        board = new();
        board.reset_settings();
        calm        = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        cfg_en      = 1'b0;
        cfg_index   = REG_TIME_STEP;
        cfg_data    = '0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        for (int k = 0; k < 12; k++)
        begin
            cell_in[k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults with dt zero, then directed extremes with a unit time step.
        for (int d = 0; d < 22; d++)
        begin
            if (d == 4)
            begin
                in_valid <= 1'b0;
                drain();
                write_setting(REG_TIME_STEP, creg_t'(32'h0001_0000));
                write_setting(REG_UPWIND_DX_QUARTER, creg_t'(32'h0000_4000));
                write_setting(REG_UPWIND_DY_QUARTER, creg_t'(32'h0000_4000));
            end
            for (int k = 0; k < 12; k++)
            begin
                case (d % 6)
                    0: c[k] = VALUE_MAX;
                    1: c[k] = VALUE_MIN;
                    2: c[k] = (k % 2) ? VALUE_MAX : VALUE_MIN;
                    3: c[k] = '0;
                    4: c[k] = value_t'(32'sh0001_0000 * (k - 6));
                    default: c[k] = pick_value();
                endcase
            end
            send_cell(c);
        end
        in_valid <= 1'b0;
        drain();

        write_setting(REG_TIME_STEP, '1);
        write_setting(REG_INV_REYNOLDS, '1);
        write_setting(REG_INV_DX_SQUARED, '1);
        write_setting(REG_INV_DY_SQUARED, '1);
        write_setting(REG_INV_DX_QUARTER, '1);
        write_setting(REG_INV_DY_QUARTER, '1);
        write_setting(REG_UPWIND_DX_QUARTER, '1);
        write_setting(REG_UPWIND_DY_QUARTER, '1);
        random_cells(150);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            random_settings();
            random_cells((RANDOM_ITEMS - 150 - CALM_ITEMS) / 6);
            drain();
        end

        for (int k = 0; k < 8; k++)
        begin
            write_setting(index_t'(k), '0);
        end
        random_cells(50);
        drain();
        board.reset_settings();
        for (int k = 0; k < 8; k++)
        begin
            write_setting(index_t'(k), creg_t'(board.settings[k]));
        end
        write_setting(REG_TIME_STEP, creg_t'(32'h0000_1000));
        calm = 1'b1;
        random_cells(CALM_ITEMS - 50);
        drain();

        if (board.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
